/* src/rvlru_pkg.sv */
// Package for the recent-value LRU sorted set: default sizes and reset layout helpers.
`default_nettype none

package rvlru_pkg;

  localparam int DefEntryCount = 12;
  localparam int DefValueBits  = 6;

  // Port widths of the result and input beats.
  localparam int InValueW  = 6;
  localparam int SlotW     = 4;
  localparam int OutValueW = 6;
  localparam int RecencyW  = 4;

  // Returns which original entry (value i+1 wrapped, rank i) lands at sorted
  // position p after a stable ascending sort of the reset contents.
  function automatic int reset_source(input int p, input int n, input int vb);
    int i;
    int j;
    int pos;
    int vi;
    int vj;
    int mask;
    int res;
    mask = (1 << vb) - 1;
    res  = 0;
    for (i = 0; i < n; i++) begin
      vi  = (i + 1) & mask;
      pos = 0;
      for (j = 0; j < n; j++) begin
        vj = (j + 1) & mask;
        if ((vj < vi) || ((vj == vi) && (j < i))) begin
          pos = pos + 1;
        end
      end
      if (pos == p) begin
        res = i;
      end
    end
    return res;
  endfunction

  function automatic int reset_value(input int p, input int n, input int vb);
    int src;
    src = reset_source(p, n, vb);
    return (src + 1) & ((1 << vb) - 1);
  endfunction

endpackage

`default_nettype wire

/* src/recent_value_lru_sorted_set.sv */
// Recent-value LRU sorted set: top level with scan sequencer, update and emit stages.
`default_nettype none

// The block holds ENTRY_COUNT distinct values, kept in ascending value order,
// each with a recency rank (0 is the most recent). Every input beat is a value
// to touch or insert. If the value is already held, that entry becomes rank 0
// and every entry that was more recent moves one rank older. Otherwise the
// oldest entry is replaced by the new value at rank 0, every other entry ages
// by one rank, and the new value is placed at its sorted position. After each
// input the whole set goes out as ENTRY_COUNT result beats in ascending value
// order, with is_last high on the final beat. Only the low VALUE_BITS bits of
// the input value are used. The block takes one input at a time: a single
// compare unit walks the entries one per cycle to find a match, the oldest
// entry and the insert position, an apply step then updates every entry,
// and the result beats go out one per cycle while out_ready is high. The
// input ready is high only while the block is idle.
module recent_value_lru_sorted_set
  import rvlru_pkg::*;
#(
  parameter int ENTRY_COUNT = DefEntryCount,
  parameter int VALUE_BITS  = DefValueBits
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [InValueW-1:0]   value,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [SlotW-1:0]     slot,
  output logic [OutValueW-1:0] entry_value,
  output logic [RecencyW-1:0]  recency,
  output logic                 is_last
);

  localparam int IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRY_COUNT + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRY_COUNT - 1);
  localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(ENTRY_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // Entry storage, sorted by value.
  logic [VALUE_BITS-1:0] held [ENTRY_COUNT];
  logic [RANK_W-1:0]     rank [ENTRY_COUNT];
  logic [VALUE_BITS-1:0] held_next [ENTRY_COUNT];
  logic [RANK_W-1:0]     rank_next [ENTRY_COUNT];

  // Sequencer and scan results.
  logic [1:0]            state;
  logic [IDX_W-1:0]      idx;
  logic [VALUE_BITS-1:0] key;
  logic                  found;
  logic [IDX_W-1:0]      hit_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [IDX_W-1:0]      vic_idx;
  logic [RANK_W-1:0]     vic_rank;
  logic                  vic_lt;
  logic [CNT_W-1:0]      lt_cnt;

  // The shared compare unit looks at the entry under the scan index.
  logic [VALUE_BITS-1:0] cur_val;
  logic [RANK_W-1:0]     cur_rank;
  logic                  cur_eq;
  logic                  cur_lt;
  logic [IDX_W-1:0]      ins_pos;

  // Width adapters between the fixed port widths and the parameter widths.
  logic [InValueW+VALUE_BITS-1:0]  value_ext;
  logic [IDX_W+SlotW-1:0]          slot_ext;
  logic [VALUE_BITS+OutValueW-1:0] outv_ext;
  logic [RANK_W+RecencyW-1:0]      rec_ext;

  assign cur_val  = held[idx];
  assign cur_rank = rank[idx];
  assign cur_eq   = (cur_val == key);
  assign cur_lt   = (cur_val < key);

  // On a miss no entry equals the key, so the new value lands after every
  // other entry that is smaller than it.
  assign ins_pos = IDX_W'(lt_cnt - CNT_W'(vic_lt));

  assign value_ext = {{VALUE_BITS{1'b0}}, value};
  assign slot_ext  = {{SlotW{1'b0}}, idx};
  assign outv_ext  = {{OutValueW{1'b0}}, held[idx]};
  assign rec_ext   = {{RecencyW{1'b0}}, rank[idx]};

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign slot        = slot_ext[SlotW-1:0];
  assign entry_value = outv_ext[OutValueW-1:0];
  assign recency     = rec_ext[RecencyW-1:0];
  assign is_last     = (idx == LAST_IDX);

  // Update of all entries, applied at once in the apply state after the scan. Each
  // position takes its own entry or a neighbor, so the lanes are independent.
  always_comb begin : apply_logic
    int s;
    logic [RANK_W-1:0] rs;
    for (int p = 0; p < ENTRY_COUNT; p++) begin
      s  = p;
      rs = '0;
      if (found) begin
        held_next[p] = held[p];
        if (IDX_W'(p) == hit_idx) begin
          rank_next[p] = '0;
        end else if (rank[p] < hit_rank) begin
          rank_next[p] = rank[p] + RANK_W'(1);
        end else begin
          rank_next[p] = rank[p];
        end
      end else if (IDX_W'(p) == ins_pos) begin
        held_next[p] = key;
        rank_next[p] = '0;
      end else begin
        if (IDX_W'(p) > ins_pos) begin
          s = p - 1;
        end
        if (IDX_W'(s) >= vic_idx) begin
          s = s + 1;
        end
        held_next[p] = held[IDX_W'(s)];
        rs           = rank[IDX_W'(s)];
        rank_next[p] = (rs < MAX_RANK) ? rs + RANK_W'(1) : rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      for (int p = 0; p < ENTRY_COUNT; p++) begin
        held[p] <= VALUE_BITS'(reset_value(p, ENTRY_COUNT, VALUE_BITS));
        rank[p] <= RANK_W'(reset_source(p, ENTRY_COUNT, VALUE_BITS));
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key    <= value_ext[VALUE_BITS-1:0];
            found  <= 1'b0;
            lt_cnt <= '0;
            idx    <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!found && cur_eq) begin
            found    <= 1'b1;
            hit_idx  <= idx;
            hit_rank <= cur_rank;
          end
          // First entry holding the oldest rank is the replacement victim.
          if ((idx == '0) || (cur_rank > vic_rank)) begin
            vic_idx  <= idx;
            vic_rank <= cur_rank;
            vic_lt   <= cur_lt;
          end
          lt_cnt <= lt_cnt + CNT_W'(cur_lt);
          if (idx == LAST_IDX) begin
            state <= ST_APPLY;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_APPLY: begin
          for (int p = 0; p < ENTRY_COUNT; p++) begin
            held[p] <= held_next[p];
            rank[p] <= rank_next[p];
          end
          idx   <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
